@@ hw/rtl/fmt_pkg.sv @@
// Shared types, constants and table-building functions for the FM tone sample generator.
// Depends on nothing; every other file of the block imports it.
package fmt_pkg;

    // Default values of the top-level parameters.
    localparam int PHASE_BITS_DEF      = 32;
    localparam int TABLE_ADDR_BITS_DEF = 10;
    localparam int SAMPLE_BITS_DEF     = 16;
    localparam int COUNT_BITS_DEF      = 24;
    localparam int QUEUE_DEPTH_DEF     = 4;

    // Fixed widths of the configuration port and of the register fields.
    localparam int CFG_DATA_BITS  = 32;
    localparam int CFG_INDEX_BITS = 3;
    localparam int RUN_LEN_BITS   = 24;
    localparam int INDEX_BITS     = 24;
    localparam int AMP_BITS       = 16;
    localparam int TABLE_BITS     = 16;

    localparam logic [RUN_LEN_BITS-1:0] RUN_LENGTH_RESET = RUN_LEN_BITS'(1);

    // Constants of the sine table build: two pi and one half in Q30, and the table peak.
    localparam logic [63:0]        TWO_PI_Q30 = 64'd6746518852;
    localparam logic signed [63:0] HALF_Q30   = 64'sd536870912;
    localparam logic signed [63:0] TABLE_PEAK = 64'sd32767;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_CARRIER_STEP   = 3'd0,
        REG_MOD_STEP       = 3'd1,
        REG_CARRIER_OFFSET = 3'd2,
        REG_MOD_OFFSET     = 3'd3,
        REG_MOD_INDEX      = 3'd4,
        REG_AMPLITUDE      = 3'd5,
        REG_RUN_LENGTH     = 3'd6
    } cfg_reg_t;

    typedef struct packed {
        logic [31:0]                  carrier_step;
        logic [31:0]                  mod_step;
        logic [31:0]                  carrier_offset;
        logic [31:0]                  mod_offset;
        logic signed [INDEX_BITS-1:0] mod_index;
        logic [AMP_BITS-1:0]          amplitude;
        logic [RUN_LEN_BITS-1:0]      run_length;
    } fmt_cfg_t;

    // One quarter-wave sine value, round(32767 * sin(2*pi*m/2^addr_bits)), from a Q30
    // Taylor series. Only ever evaluated on constants while the design elaborates.
    function automatic logic signed [TABLE_BITS-1:0] quarter_sine(input logic [63:0] m,
                                                                  input int addr_bits);
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic signed [63:0] v;
        x    = (TWO_PI_Q30 * m) >> addr_bits;
        x2   = (x * x) >> 30;
        term = x;
        sum  = $signed(x);
        for (int n = 1; n <= 12; n++) begin
            term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
            if (n % 2 == 1)
                sum = sum - $signed(term);
            else
                sum = sum + $signed(term);
        end
        if (sum < 0)
            sum = 0;
        v = (sum * TABLE_PEAK + HALF_Q30) >>> 30;
        if (v > TABLE_PEAK)
            v = TABLE_PEAK;
        return TABLE_BITS'(v);
    endfunction

    // Full-wave table entry k, built from the quarter wave by symmetry.
    function automatic logic signed [TABLE_BITS-1:0] sine_entry(input int k,
                                                                input int addr_bits);
        int                           q4;
        int                           quad;
        int                           r;
        logic signed [TABLE_BITS-1:0] s;
        q4   = 1 << (addr_bits - 2);
        quad = k >> (addr_bits - 2);
        r    = k & (q4 - 1);
        s    = quad[0] ? quarter_sine(64'(q4 - r), addr_bits) : quarter_sine(64'(r), addr_bits);
        return quad[1] ? -s : s;
    endfunction

endpackage

@@ hw/rtl/fmt_front.sv @@
// Front end of the FM tone sample generator: accepts sample requests, advances the two
// phase accumulators and the run counter, and queues phase bases and the last flag.
// Depends on fmt_pkg.
module fmt_front
    import fmt_pkg::*;
#(
    parameter int PHASE_BITS = PHASE_BITS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  fmt_cfg_t                cfg,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic                    restart,
    output logic                    push_valid,
    output logic [2*PHASE_BITS:0]   push_data,
    input  logic                    push_ready
);

    localparam int CMP_BITS = ((COUNT_BITS > RUN_LEN_BITS) ? COUNT_BITS : RUN_LEN_BITS) + 1;

    logic [PHASE_BITS-1:0] carrier_acc_reg, carrier_acc_next;
    logic [PHASE_BITS-1:0] mod_acc_reg, mod_acc_next;
    logic [COUNT_BITS-1:0] run_count_reg, run_count_next;

    logic [PHASE_BITS-1:0]   carrier_cur;
    logic [PHASE_BITS-1:0]   mod_cur;
    logic [COUNT_BITS-1:0]   count_cur;
    logic [RUN_LEN_BITS-1:0] run_len;
    logic [CMP_BITS-1:0]     count_plus;
    logic                    last_flag;
    logic                    accept;

    assign in_ready   = push_ready;
    assign push_valid = in_valid;
    assign accept     = in_valid && push_ready;

    always_comb
    begin
        carrier_cur = restart ? '0 : carrier_acc_reg;
        mod_cur     = restart ? '0 : mod_acc_reg;
        count_cur   = restart ? '0 : run_count_reg;

        // A zero run length behaves as one; a full counter always ends the run.
        run_len    = (cfg.run_length == '0) ? RUN_LEN_BITS'(1) : cfg.run_length;
        count_plus = CMP_BITS'(count_cur) + CMP_BITS'(1);
        last_flag  = (count_plus >= CMP_BITS'(run_len)) || (&count_cur);

        run_count_next   = last_flag ? '0 : (count_cur + COUNT_BITS'(1));
        carrier_acc_next = carrier_cur + PHASE_BITS'(cfg.carrier_step);
        mod_acc_next     = mod_cur + PHASE_BITS'(cfg.mod_step);

        push_data = {last_flag,
                     carrier_cur + PHASE_BITS'(cfg.carrier_offset),
                     mod_cur + PHASE_BITS'(cfg.mod_offset)};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            carrier_acc_reg <= '0;
            mod_acc_reg     <= '0;
            run_count_reg   <= '0;
        end
        else if (accept)
        begin
            carrier_acc_reg <= carrier_acc_next;
            mod_acc_reg     <= mod_acc_next;
            run_count_reg   <= run_count_next;
        end
    end

endmodule

@@ hw/rtl/fmt_fifo.sv @@
// Short register queue between the front end and the synthesis pipeline.
// Depends on fmt_pkg for its default depth.
module fmt_fifo
    import fmt_pkg::*;
#(
    parameter int WIDTH = 1,
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data
);

    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]    mem_reg [DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0] count_reg, count_next;
    logic                do_push;
    logic                do_pop;

    assign push_ready = (count_reg != CNT_BITS'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = (wr_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_BITS'(1);
        rd_ptr_next = (rd_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_BITS'(1);
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + CNT_BITS'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - CNT_BITS'(1);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_next;
            if (do_pop)
                rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

endmodule

@@ hw/rtl/fmt_back.sv @@
// Synthesis pipeline of the FM tone sample generator: cosine lookup, index multiply,
// phase subtraction, sine lookup, amplitude multiply, rounding and saturation.
// Depends on fmt_pkg for the sine table and the configuration type.
module fmt_back
    import fmt_pkg::*;
#(
    parameter int PHASE_BITS      = PHASE_BITS_DEF,
    parameter int TABLE_ADDR_BITS = TABLE_ADDR_BITS_DEF,
    parameter int SAMPLE_BITS     = SAMPLE_BITS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  fmt_cfg_t                      cfg,
    input  logic                          head_valid,
    input  logic [2*PHASE_BITS:0]         head_data,
    output logic                          head_pop,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [SAMPLE_BITS-1:0] sample,
    output logic                          last
);

    localparam int TBL_SIZE   = 1 << TABLE_ADDR_BITS;
    localparam int UP         = (PHASE_BITS >= 31) ? PHASE_BITS - 31 : 0;
    localparam int DOWN       = (PHASE_BITS < 31) ? 31 - PHASE_BITS : 0;
    localparam int RSH        = 31 - SAMPLE_BITS;
    localparam int PROD_BITS  = TABLE_BITS + INDEX_BITS;
    localparam int AMP_P_BITS = TABLE_BITS + AMP_BITS + 1;
    localparam int RND_BITS   = AMP_P_BITS + 1;

    localparam logic [TABLE_ADDR_BITS-1:0] QUARTER    = TABLE_ADDR_BITS'(TBL_SIZE / 4);
    localparam logic signed [RND_BITS-1:0] ROUND_HALF = RND_BITS'(64'sd1 << (RSH - 1));
    localparam logic signed [RND_BITS-1:0] SAT_HI     =
        RND_BITS'((64'sd1 << (SAMPLE_BITS - 1)) - 64'sd1);
    localparam logic signed [RND_BITS-1:0] SAT_LO     = -SAT_HI - RND_BITS'(1);

    logic signed [TABLE_BITS-1:0] sine_rom [TBL_SIZE];

    for (genvar k = 0; k < TBL_SIZE; k++)
    begin : g_rom
        assign sine_rom[k] = sine_entry(k, TABLE_ADDR_BITS);
    end

    logic                        advance;
    logic                        last_in;
    logic [PHASE_BITS-1:0]       cbase_in;
    logic [PHASE_BITS-1:0]       mphase_in;
    logic [TABLE_ADDR_BITS-1:0]  cos_addr;

    // Stage 1: cosine of the modulation phase.
    logic                         v1_reg;
    logic signed [TABLE_BITS-1:0] c1_reg;
    logic [PHASE_BITS-1:0]        cbase1_reg;
    logic                         last1_reg;
    // Stage 2: cosine times modulation index.
    logic                         v2_reg;
    logic signed [PROD_BITS-1:0]  prod2_reg, prod2_next;
    logic [PHASE_BITS-1:0]        cbase2_reg;
    logic                         last2_reg;
    // Stage 3: table address of the modulated carrier phase.
    logic                         v3_reg;
    logic [TABLE_ADDR_BITS-1:0]   addr3_reg;
    logic                         last3_reg;
    logic [PHASE_BITS-1:0]        delta;
    logic [PHASE_BITS-1:0]        arg_next;
    // Stage 4: sine of the modulated phase.
    logic                         v4_reg;
    logic signed [TABLE_BITS-1:0] s4_reg;
    logic                         last4_reg;
    // Stage 5: sine times amplitude.
    logic                         v5_reg;
    logic signed [AMP_P_BITS-1:0] ap5_reg, ap5_next;
    logic                         last5_reg;
    // Output register.
    logic                         out_valid_reg;
    logic signed [SAMPLE_BITS-1:0] sample_reg, sample_next;
    logic                         last_reg;
    logic signed [RND_BITS-1:0]   rounded;

    // The whole pipeline moves together; it holds only while a result waits.
    assign advance  = !out_valid_reg || out_ready;
    assign head_pop = advance && head_valid;

    assign last_in   = head_data[2*PHASE_BITS];
    assign cbase_in  = head_data[2*PHASE_BITS-1:PHASE_BITS];
    assign mphase_in = head_data[PHASE_BITS-1:0];
    assign cos_addr  = mphase_in[PHASE_BITS-1 -: TABLE_ADDR_BITS] + QUARTER;

    always_comb
    begin
        prod2_next = PROD_BITS'(c1_reg) * PROD_BITS'(cfg.mod_index);
        // Q31 cycle count scaled to the phase width, floor on a right shift.
        delta      = PHASE_BITS'(prod2_reg >>> DOWN) << UP;
        arg_next   = cbase2_reg - delta;
        ap5_next   = AMP_P_BITS'(s4_reg) * $signed({1'b0, cfg.amplitude});
        rounded    = (RND_BITS'(ap5_reg) + ROUND_HALF) >>> RSH;
        if (rounded > SAT_HI)
            sample_next = SAMPLE_BITS'(SAT_HI);
        else if (rounded < SAT_LO)
            sample_next = SAMPLE_BITS'(SAT_LO);
        else
            sample_next = SAMPLE_BITS'(rounded);
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            c1_reg     <= sine_rom[cos_addr];
            cbase1_reg <= cbase_in;
            last1_reg  <= last_in;
            prod2_reg  <= prod2_next;
            cbase2_reg <= cbase1_reg;
            last2_reg  <= last1_reg;
            addr3_reg  <= arg_next[PHASE_BITS-1 -: TABLE_ADDR_BITS];
            last3_reg  <= last2_reg;
            s4_reg     <= sine_rom[addr3_reg];
            last4_reg  <= last3_reg;
            ap5_reg    <= ap5_next;
            last5_reg  <= last4_reg;
            if (v5_reg)
            begin
                sample_reg <= sample_next;
                last_reg   <= last5_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            v5_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            v1_reg        <= head_valid;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            v4_reg        <= v3_reg;
            v5_reg        <= v4_reg;
            out_valid_reg <= v5_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign sample    = sample_reg;
    assign last      = last_reg;

endmodule

@@ hw/rtl/fm_tone_sample_generator_top.sv @@
// FM tone sample generator: one sample of amp*sin(carrier - index*cos(mod)) per request.
// Depends on fmt_pkg, fmt_front, fmt_fifo and fmt_back.
//
// Each transfer on the input channel requests one tone sample and produces exactly one
// transfer on the output channel, in order. The restart bit of a request zeroes both phase
// accumulators and the run counter before that sample is computed; the last output marks
// the final sample of each run of run_length samples, and phases carry on across runs.
// The block sustains one sample per clock while the output is not held off: the front
// end advances the accumulators once per request, and the synthesis pipeline behind it
// has six register stages (cosine lookup, index multiply, phase subtraction, sine lookup,
// amplitude multiply, rounding with saturation into the output register). A queue of
// QUEUE_DEPTH entries separates the two halves, so requests keep being taken while the
// output side is held off, until the queue fills. Configuration is written through
// cfg_write, cfg_index and cfg_data with no wait state; registers should only be changed
// while no sample is in flight. Phase registers wider than PHASE_BITS use only their low
// bits; a run length of zero acts as one.
module fm_tone_sample_generator_top
    import fmt_pkg::*;
#(
    parameter int PHASE_BITS      = PHASE_BITS_DEF,
    parameter int TABLE_ADDR_BITS = TABLE_ADDR_BITS_DEF,
    parameter int SAMPLE_BITS     = SAMPLE_BITS_DEF,
    parameter int COUNT_BITS      = COUNT_BITS_DEF,
    parameter int QUEUE_DEPTH     = QUEUE_DEPTH_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic [CFG_INDEX_BITS-1:0]     cfg_index,
    input  logic [CFG_DATA_BITS-1:0]      cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          restart,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [SAMPLE_BITS-1:0] sample,
    output logic                          last
);

    localparam int ENTRY_BITS = 2 * PHASE_BITS + 1;

    fmt_cfg_t cfg_reg;

    logic                  push_valid;
    logic                  push_ready;
    logic [ENTRY_BITS-1:0] push_data;
    logic                  head_valid;
    logic                  head_pop;
    logic [ENTRY_BITS-1:0] head_data;

    // Register file; writes to indexes past the list are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{carrier_step:   '0,
                         mod_step:       '0,
                         carrier_offset: '0,
                         mod_offset:     '0,
                         mod_index:      '0,
                         amplitude:      '0,
                         run_length:     RUN_LENGTH_RESET};
        end
        else if (cfg_write)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_CARRIER_STEP:   cfg_reg.carrier_step   <= cfg_data;
                REG_MOD_STEP:       cfg_reg.mod_step       <= cfg_data;
                REG_CARRIER_OFFSET: cfg_reg.carrier_offset <= cfg_data;
                REG_MOD_OFFSET:     cfg_reg.mod_offset     <= cfg_data;
                REG_MOD_INDEX:      cfg_reg.mod_index      <= INDEX_BITS'(cfg_data);
                REG_AMPLITUDE:      cfg_reg.amplitude      <= AMP_BITS'(cfg_data);
                REG_RUN_LENGTH:     cfg_reg.run_length     <= RUN_LEN_BITS'(cfg_data);
                default:            ;
            endcase
        end
    end

    fmt_front #(
        .PHASE_BITS (PHASE_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .restart    (restart),
        .push_valid (push_valid),
        .push_data  (push_data),
        .push_ready (push_ready)
    );

    fmt_fifo #(
        .WIDTH (ENTRY_BITS),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (head_valid),
        .pop        (head_pop),
        .pop_data   (head_data)
    );

    fmt_back #(
        .PHASE_BITS      (PHASE_BITS),
        .TABLE_ADDR_BITS (TABLE_ADDR_BITS),
        .SAMPLE_BITS     (SAMPLE_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .head_valid (head_valid),
        .head_data  (head_data),
        .head_pop   (head_pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .sample     (sample),
        .last       (last)
    );

endmodule
